// ----- hdl/uww_pkg.sv -----
// Shared constants, types and helpers of the UTF-8 word wrap line breaker
package uww_pkg;

	localparam int unsigned ADDR_W      = 6;
	localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
	localparam int unsigned LINE_CAP    = STORE_DEPTH - 1;
	localparam int unsigned LIMIT_W     = 6;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned SPAN_CNT_W  = 2;
	localparam int unsigned NUM_SLOTS   = 7;
	localparam int unsigned SLOT_W      = 3;

	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	localparam logic [SLOT_W-1:0] SLOT_EXT   = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_HEAD  = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_SPAN  = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_LF    = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_TAIL  = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_FLUSH = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_END   = 3'd6;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [ADDR_W:0]      count_t;
	typedef logic [LIMIT_W-1:0]   limit_t;
	typedef logic [NUM_SLOTS-1:0] slot_mask_t;

	typedef enum logic {
		CMD_BYTE,
		CMD_SPAN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       data_valid;
		addr_t      addr;
		addr_t      len;
		logic       last;
		logic       done;
	} cmd_t;

	typedef struct packed {
		logic       en;
		addr_t      addr;
		logic [7:0] data;
	} store_wr_t;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == BYTE_SPACE) || (b == BYTE_TAB);
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

endpackage

// ----- hdl/uww_if.sv -----
// Channel interfaces: input bytes, wrapped output bytes, limit register writes
interface uww_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface uww_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_of_run;
	logic       text_done;

	modport source (output valid, output out_byte, output byte_valid, output last_of_run,
		output text_done, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
		input text_done, output ready);
endinterface

interface uww_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] line_limit;

	modport source (output valid, output line_limit, input ready);
	modport sink (input valid, input line_limit, output ready);
endinterface

// ----- hdl/utf8_word_wrap_line_breaker_core.sv -----
// Top level of the UTF-8 word wrap line breaker
//
//  channel   | dir | payload                                          | request
//  ----------+-----+--------------------------------------------------+------------------------
//  byte_in   | in  | in_byte[7:0], end_of_text                        | one text byte
//  byte_out  | out | out_byte[7:0], byte_valid, last_of_run, text_done| one wrapped byte/marker
//  cfg       | in  | line_limit[5:0]                                  | limit write, always ready
//
//  The front end plans all results of an input request and hands them over one per cycle
//  while the command queue has room; the next request is taken once all are handed over.
//  A line break or flush streams held bytes from the line store at one per cycle while the
//  output is not stalled, and input is held off until that readout has left the store.
//  Output stalls fill the 4-entry command queue and then stall input.
//  Reset clears all control state at once; the line store needs no clearing.
module utf8_word_wrap_line_breaker_core (
	input logic     clk,
	input logic     arst_n,
	uww_in_if.sink  byte_in,
	uww_out_if.source byte_out,
	uww_cfg_if.sink cfg
);

	logic               push_valid;
	logic               push_ready;
	uww_pkg::cmd_t      push_data;
	logic               pop_valid;
	logic               pop_ready;
	uww_pkg::cmd_t      pop_data;
	logic               span_done;
	logic               span_busy;
	uww_pkg::store_wr_t store_wr;

	uww_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.span_done  (span_done),
		.store_wr   (store_wr),
		.span_busy  (span_busy)
	);

	uww_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	uww_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.store_wr  (store_wr),
		.span_done (span_done),
		.byte_out  (byte_out)
	);

	a_marker_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && !byte_out.byte_valid |-> byte_out.text_done && byte_out.last_of_run)
		else $error("end-only marker outside the end of text");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		byte_out.valid && byte_out.text_done |-> byte_out.last_of_run)
		else $error("text_done without last_of_run");

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> !span_busy)
		else $error("line store written during span readout");

	a_span_counted: assert property (@(posedge clk) disable iff (!arst_n)
		span_done |-> span_busy)
		else $error("span finished with none outstanding");

endmodule

// ----- hdl/uww_front.sv -----
// Front end: accepts bytes, tracks the line, plans and issues output commands
module uww_front (
	input  logic               clk,
	input  logic               arst_n,
	uww_in_if.sink             byte_in,
	uww_cfg_if.sink            cfg,
	output logic               push_valid,
	input  logic               push_ready,
	output uww_pkg::cmd_t      push_data,
	input  logic               span_done,
	output uww_pkg::store_wr_t store_wr,
	output logic               span_busy
);

	uww_pkg::limit_t     limit_q;
	uww_pkg::limit_t     lim_q;
	uww_pkg::addr_t      base_q;
	uww_pkg::addr_t      fill_q;
	logic                skip_q;
	logic                ext_q;
	logic                hb_q;
	logic                lb_vld_q;
	uww_pkg::addr_t      lb_q;
	uww_pkg::addr_t      rs_q;
	uww_pkg::addr_t      nc_q;
	logic                eot_q;
	uww_pkg::slot_mask_t mask_q;
	uww_pkg::cmd_t       plan_q [uww_pkg::NUM_SLOTS];
	logic [uww_pkg::SPAN_CNT_W-1:0] span_cnt_q;

	logic                accept;
	logic [7:0]          b;
	logic                b_blank;
	logic                b_cont;
	logic                line_empty;
	logic                take;
	logic                prev_blank;
	logic                skh;
	logic                wr_en_d;
	uww_pkg::limit_t     lim;
	uww_pkg::addr_t      base_d;
	uww_pkg::count_t     fill_d;
	uww_pkg::count_t     fill1;
	uww_pkg::count_t     ws;
	uww_pkg::count_t     rest;
	uww_pkg::addr_t      split;
	logic                skip_d;
	logic                ext_d;
	logic                hb_d;
	logic                lb_vld_d;
	uww_pkg::addr_t      lb_d;
	uww_pkg::addr_t      rs_d;
	uww_pkg::addr_t      nc_d;
	uww_pkg::slot_mask_t mask_d;
	uww_pkg::cmd_t       plan_d [uww_pkg::NUM_SLOTS];

	logic [uww_pkg::SLOT_W-1:0] pick;
	logic                found;
	uww_pkg::slot_mask_t pick_oh;
	uww_pkg::slot_mask_t rest_mask;
	logic                push_fire;
	logic                span_push;

	assign cfg.ready     = 1'b1;
	assign byte_in.ready = (mask_q == '0) && (span_cnt_q == '0);
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.in_byte;
	assign b_blank       = uww_pkg::is_blank(b);
	assign b_cont        = uww_pkg::is_cont(b);
	assign line_empty    = (fill_q == '0);
	assign span_busy     = (span_cnt_q != '0);

	always_comb begin
		if (line_empty && !skip_q && !ext_q) begin
			lim = (limit_q > uww_pkg::LINE_CAP) ? uww_pkg::limit_t'(uww_pkg::LINE_CAP) : limit_q;
		end else begin
			lim = lim_q;
		end
		for (int k = 0; k < uww_pkg::NUM_SLOTS; k++) begin
			plan_d[k] = '0;
		end
		mask_d     = '0;
		base_d     = base_q;
		fill_d     = uww_pkg::count_t'(fill_q);
		fill1      = uww_pkg::count_t'(fill_q) + uww_pkg::count_t'(1);
		ws         = '0;
		rest       = '0;
		split      = '0;
		skh        = 1'b0;
		skip_d     = skip_q;
		ext_d      = ext_q;
		hb_d       = hb_q;
		lb_vld_d   = lb_vld_q && !line_empty;
		lb_d       = lb_q;
		rs_d       = rs_q;
		nc_d       = line_empty ? '0 : nc_q;
		prev_blank = lb_vld_d && ((lb_q + uww_pkg::addr_t'(1)) == fill_q);
		wr_en_d    = 1'b0;
		take       = 1'b1;

		if (ext_q) begin
			mask_d[uww_pkg::SLOT_EXT]            = 1'b1;
			plan_d[uww_pkg::SLOT_EXT].kind       = uww_pkg::CMD_BYTE;
			plan_d[uww_pkg::SLOT_EXT].data       = b_cont ? b : uww_pkg::BYTE_LF;
			plan_d[uww_pkg::SLOT_EXT].data_valid = 1'b1;
			if (b_cont) begin
				take = 1'b0;
			end else begin
				ext_d = 1'b0;
			end
		end

		if (take) begin
			if (lim == '0) begin
				mask_d[uww_pkg::SLOT_HEAD]            = 1'b1;
				plan_d[uww_pkg::SLOT_HEAD].kind       = uww_pkg::CMD_BYTE;
				plan_d[uww_pkg::SLOT_HEAD].data       = b;
				plan_d[uww_pkg::SLOT_HEAD].data_valid = 1'b1;
			end else if (b == uww_pkg::BYTE_LF) begin
				skh                                   = !line_empty && !hb_q;
				plan_d[uww_pkg::SLOT_SPAN].kind       = uww_pkg::CMD_SPAN;
				plan_d[uww_pkg::SLOT_SPAN].addr       = base_q + uww_pkg::addr_t'(skh);
				plan_d[uww_pkg::SLOT_SPAN].len        = fill_q - uww_pkg::addr_t'(skh);
				mask_d[uww_pkg::SLOT_SPAN]            = (fill_q != uww_pkg::addr_t'(skh));
				mask_d[uww_pkg::SLOT_LF]              = 1'b1;
				plan_d[uww_pkg::SLOT_LF].kind         = uww_pkg::CMD_BYTE;
				plan_d[uww_pkg::SLOT_LF].data         = uww_pkg::BYTE_LF;
				plan_d[uww_pkg::SLOT_LF].data_valid   = 1'b1;
				fill_d                                = '0;
				skip_d                                = 1'b0;
			end else if (skip_q && b_blank) begin
				skip_d = 1'b1;
			end else begin
				skip_d  = 1'b0;
				wr_en_d = 1'b1;
				fill_d  = fill1;
				if (line_empty) begin
					hb_d = b_blank;
				end
				if (b_blank) begin
					rs_d     = prev_blank ? rs_q : fill_q;
					lb_d     = fill_q;
					lb_vld_d = 1'b1;
				end
				if (!line_empty && !b_cont) begin
					nc_d = fill_q;
				end
				if (line_empty && !b_blank) begin
					mask_d[uww_pkg::SLOT_HEAD]            = 1'b1;
					plan_d[uww_pkg::SLOT_HEAD].kind       = uww_pkg::CMD_BYTE;
					plan_d[uww_pkg::SLOT_HEAD].data       = b;
					plan_d[uww_pkg::SLOT_HEAD].data_valid = 1'b1;
				end
				if (fill1 > uww_pkg::count_t'(lim)) begin
					split                              = nc_d;
					plan_d[uww_pkg::SLOT_SPAN].kind    = uww_pkg::CMD_SPAN;
					plan_d[uww_pkg::SLOT_LF].kind      = uww_pkg::CMD_BYTE;
					plan_d[uww_pkg::SLOT_LF].data      = uww_pkg::BYTE_LF;
					plan_d[uww_pkg::SLOT_LF].data_valid = 1'b1;
					plan_d[uww_pkg::SLOT_TAIL].kind    = uww_pkg::CMD_SPAN;
					plan_d[uww_pkg::SLOT_TAIL].len     = uww_pkg::addr_t'(1);
					if (lb_vld_d) begin
						ws   = uww_pkg::count_t'(lb_d) + uww_pkg::count_t'(1);
						rest = fill1 - ws;
						skh  = (rs_d != '0) && !hb_d;
						plan_d[uww_pkg::SLOT_SPAN].addr = base_q + uww_pkg::addr_t'(skh);
						plan_d[uww_pkg::SLOT_SPAN].len  = rs_d - uww_pkg::addr_t'(skh);
						mask_d[uww_pkg::SLOT_SPAN]      = (rs_d != uww_pkg::addr_t'(skh));
						mask_d[uww_pkg::SLOT_LF]        = 1'b1;
						plan_d[uww_pkg::SLOT_TAIL].addr = base_q + ws[uww_pkg::ADDR_W-1:0];
						mask_d[uww_pkg::SLOT_TAIL]      = (rest != '0);
						base_d   = base_q + ws[uww_pkg::ADDR_W-1:0];
						fill_d   = rest;
						skip_d   = (rest == '0);
						hb_d     = 1'b0;
						lb_vld_d = 1'b0;
						if (uww_pkg::count_t'(split) > ws) begin
							nc_d = split - ws[uww_pkg::ADDR_W-1:0];
						end else begin
							nc_d = '0;
						end
					end else if (split == '0) begin
						plan_d[uww_pkg::SLOT_SPAN].addr = base_q + uww_pkg::addr_t'(1);
						plan_d[uww_pkg::SLOT_SPAN].len  = uww_pkg::addr_t'(lim);
						mask_d[uww_pkg::SLOT_SPAN]      = 1'b1;
						fill_d = '0;
						ext_d  = 1'b1;
					end else begin
						plan_d[uww_pkg::SLOT_SPAN].addr = base_q + uww_pkg::addr_t'(1);
						plan_d[uww_pkg::SLOT_SPAN].len  = split - uww_pkg::addr_t'(1);
						mask_d[uww_pkg::SLOT_SPAN]      = (split != uww_pkg::addr_t'(1));
						mask_d[uww_pkg::SLOT_LF]        = 1'b1;
						plan_d[uww_pkg::SLOT_TAIL].addr = base_q + split;
						mask_d[uww_pkg::SLOT_TAIL]      = 1'b1;
						base_d   = base_q + split;
						fill_d   = fill1 - uww_pkg::count_t'(split);
						hb_d     = 1'b0;
						lb_vld_d = 1'b0;
						nc_d     = '0;
					end
				end
			end
		end

		if (byte_in.end_of_text) begin
			plan_d[uww_pkg::SLOT_END].kind = uww_pkg::CMD_BYTE;
			if (ext_d) begin
				mask_d[uww_pkg::SLOT_END]            = 1'b1;
				plan_d[uww_pkg::SLOT_END].data       = uww_pkg::BYTE_LF;
				plan_d[uww_pkg::SLOT_END].data_valid = 1'b1;
			end else begin
				skh = (fill_d != '0) && !hb_d;
				plan_d[uww_pkg::SLOT_FLUSH].kind = uww_pkg::CMD_SPAN;
				plan_d[uww_pkg::SLOT_FLUSH].addr = base_d + uww_pkg::addr_t'(skh);
				plan_d[uww_pkg::SLOT_FLUSH].len  =
					fill_d[uww_pkg::ADDR_W-1:0] - uww_pkg::addr_t'(skh);
				mask_d[uww_pkg::SLOT_FLUSH] = (fill_d != uww_pkg::count_t'(skh));
			end
			if (mask_d == '0) begin
				mask_d[uww_pkg::SLOT_END]            = 1'b1;
				plan_d[uww_pkg::SLOT_END].data       = '0;
				plan_d[uww_pkg::SLOT_END].data_valid = 1'b0;
			end
			fill_d = '0;
			skip_d = 1'b0;
			ext_d  = 1'b0;
		end
	end

	always_comb begin
		pick  = '0;
		found = 1'b0;
		for (int k = 0; k < uww_pkg::NUM_SLOTS; k++) begin
			if (mask_q[k] && !found) begin
				pick  = uww_pkg::SLOT_W'(k);
				found = 1'b1;
			end
		end
		pick_oh        = uww_pkg::slot_mask_t'(1) << pick;
		rest_mask      = mask_q & ~pick_oh;
		push_data      = plan_q[pick];
		push_data.last = (rest_mask == '0);
		push_data.done = (rest_mask == '0) && eot_q;
	end

	assign push_valid = (mask_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign span_push  = push_fire && (push_data.kind == uww_pkg::CMD_SPAN);

	assign store_wr.en   = accept && wr_en_d;
	assign store_wr.addr = base_q + fill_q;
	assign store_wr.data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= '0;
			lim_q      <= '0;
			base_q     <= '0;
			fill_q     <= '0;
			skip_q     <= 1'b0;
			ext_q      <= 1'b0;
			hb_q       <= 1'b0;
			lb_vld_q   <= 1'b0;
			lb_q       <= '0;
			rs_q       <= '0;
			nc_q       <= '0;
			mask_q     <= '0;
			span_cnt_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.line_limit;
			end
			if (accept) begin
				lim_q    <= lim;
				base_q   <= base_d;
				fill_q   <= fill_d[uww_pkg::ADDR_W-1:0];
				skip_q   <= skip_d;
				ext_q    <= ext_d;
				hb_q     <= hb_d;
				lb_vld_q <= lb_vld_d;
				lb_q     <= lb_d;
				rs_q     <= rs_d;
				nc_q     <= nc_d;
				mask_q   <= mask_d;
			end else if (push_fire) begin
				mask_q <= rest_mask;
			end
			case ({span_push, span_done})
				2'b10: span_cnt_q <= span_cnt_q + 1'b1;
				2'b01: span_cnt_q <= span_cnt_q - 1'b1;
				default: span_cnt_q <= span_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eot_q <= byte_in.end_of_text;
			for (int k = 0; k < uww_pkg::NUM_SLOTS; k++) begin
				plan_q[k] <= plan_d[k];
			end
		end
	end

endmodule

// ----- hdl/uww_queue.sv -----
// Command queue between the front end and the back end
module uww_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  uww_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output uww_pkg::cmd_t pop_data
);

	uww_pkg::cmd_t                 entry_q [uww_pkg::QUEUE_DEPTH];
	logic [uww_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [uww_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [uww_pkg::QPTR_W:0]      count_q;
	logic                          push_fire;
	logic                          pop_fire;

	assign push_ready = (count_q != (uww_pkg::QPTR_W + 1)'(uww_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_fire, pop_fire})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/uww_back.sv -----
// Back end: line store, span readout and output register
module uww_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  uww_pkg::cmd_t      pop_data,
	input  uww_pkg::store_wr_t store_wr,
	output logic               span_done,
	uww_out_if.source          byte_out
);

	logic [7:0]     mem [uww_pkg::STORE_DEPTH];
	uww_pkg::addr_t cnt_q;
	uww_pkg::addr_t rd_addr;

	logic           vld_s1;
	logic           mem_sel_s1;
	logic [7:0]     data_s1;
	logic [7:0]     rd_s1;
	logic           dv_s1;
	logic           last_s1;
	logic           done_s1;

	logic           out_vld_q;
	logic [7:0]     out_byte_q;
	logic           out_dv_q;
	logic           out_last_q;
	logic           out_done_q;

	logic           out_load;
	logic           s1_take;
	logic           is_span;
	logic           span_end;
	logic           issue;

	assign out_load  = vld_s1 && (!out_vld_q || byte_out.ready);
	assign s1_take   = !vld_s1 || out_load;
	assign is_span   = (pop_data.kind == uww_pkg::CMD_SPAN);
	assign span_end  = (cnt_q == (pop_data.len - uww_pkg::addr_t'(1)));
	assign issue     = pop_valid && s1_take;
	assign pop_ready = s1_take && (!is_span || span_end);
	assign span_done = issue && is_span && span_end;
	assign rd_addr   = pop_data.addr + cnt_q;

	assign byte_out.valid       = out_vld_q;
	assign byte_out.out_byte    = out_byte_q;
	assign byte_out.byte_valid  = out_dv_q;
	assign byte_out.last_of_run = out_last_q;
	assign byte_out.text_done   = out_done_q;

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem[store_wr.addr] <= store_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && is_span) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (issue && is_span) begin
				cnt_q <= span_end ? '0 : cnt_q + 1'b1;
			end
			if (s1_take) begin
				vld_s1 <= issue;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (byte_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_sel_s1 <= is_span;
			data_s1    <= pop_data.data;
			dv_s1      <= is_span || pop_data.data_valid;
			last_s1    <= pop_data.last && (!is_span || span_end);
			done_s1    <= pop_data.done && (!is_span || span_end);
		end
		if (out_load) begin
			out_byte_q <= mem_sel_s1 ? rd_s1 : data_s1;
			out_dv_q   <= dv_s1;
			out_last_q <= last_s1;
			out_done_q <= done_s1;
		end
	end

endmodule
